>>> design/gmps_pkg.sv
// shared types and constants for the grid max path sum block
package gmps_pkg;

   localparam int VALUE_W    = 16;
   localparam int SUM_W      = 24;
   localparam int ROW_OUT_W  = 6;
   localparam int ROWS_REG_W = 7;
   localparam int COLS_REG_W = 9;
   localparam int CSR_DATA_W = 16;

   typedef enum logic {
      CSR_ROWS_USED = 1'b0,
      CSR_COLS_USED = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic first_col;
      logic last_col;
      logic has_below;
      logic single_row;
      logic last_cell;
   } cell_ctl_type;

   typedef struct packed {
      logic out_full;
   } dp_status_type;

endpackage

>>> design/gmps_col_ram.sv
// column sum memory, one write and one registered read per cycle, write-first
module gmps_col_ram
   import gmps_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [SUM_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [SUM_W-1:0] rd_data
);

   logic [SUM_W-1:0] mem_ff [DEPTH];
   logic [SUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/gmps_seq.sv
// grid position counters, register file and input acceptance
module gmps_seq
   import gmps_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 256,
   parameter int RW       = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  dp_status_type         status,
   output logic                  cell_fire,
   output logic                  grid_clear,
   output logic [RW-1:0]         rd_addr,
   output logic [RW-1:0]         cell_row,
   output cell_ctl_type          cell_ctl
);

   localparam int RCW      = $clog2(MAX_ROWS + 1);
   localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CCW      = $clog2(MAX_COLS + 1);
   localparam int ROWS_RST = (MAX_ROWS < 64) ? MAX_ROWS : 64;
   localparam int COLS_RST = (MAX_COLS < 256) ? MAX_COLS : 256;

   logic [RCW-1:0]        rows_lim_ff, rows_lim_in;
   logic [CCW-1:0]        cols_lim_ff, cols_lim_in;
   logic [RW-1:0]         row_ff, row_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [ROWS_REG_W-1:0] rows_w;
   logic [COLS_REG_W-1:0] cols_w;
   logic [RCW-1:0]        rows_clamp;
   logic [CCW-1:0]        cols_clamp;
   logic [RCW-1:0]        row_inc;
   logic [CCW-1:0]        col_inc;
   logic                  has_below;
   logic                  last_col;
   logic                  last_cell;
   logic                  csr_fire;

   assign rows_w = csr_wdata[ROWS_REG_W-1:0];
   assign cols_w = csr_wdata[COLS_REG_W-1:0];

   always_comb begin
      if (rows_w == '0) begin
         rows_clamp = RCW'(1);
      end else if (int'(rows_w) > MAX_ROWS) begin
         rows_clamp = RCW'(MAX_ROWS);
      end else begin
         rows_clamp = RCW'(rows_w);
      end
      if (cols_w == '0) begin
         cols_clamp = CCW'(1);
      end else if (int'(cols_w) > MAX_COLS) begin
         cols_clamp = CCW'(MAX_COLS);
      end else begin
         cols_clamp = CCW'(cols_w);
      end
   end

   assign row_inc   = RCW'(row_ff) + RCW'(1);
   assign col_inc   = CCW'(col_ff) + CCW'(1);
   assign has_below = row_inc < rows_lim_ff;
   assign last_col  = col_inc >= cols_lim_ff;
   assign last_cell = !has_below && last_col;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign grid_clear = csr_fire;
   assign req_ready  = !(last_cell && status.out_full);
   assign cell_fire  = req_valid && req_ready;

   assign rd_addr  = has_below ? RW'(row_inc) : '0;
   assign cell_row = row_ff;

   always_comb begin
      cell_ctl.first_col  = (col_ff == '0);
      cell_ctl.last_col   = last_col;
      cell_ctl.has_below  = has_below;
      cell_ctl.single_row = (rows_lim_ff == RCW'(1));
      cell_ctl.last_cell  = last_cell;
   end

   always_comb begin
      rows_lim_in = rows_lim_ff;
      cols_lim_in = cols_lim_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      if (csr_fire) begin
         if (csr_index == CSR_ROWS_USED) begin
            rows_lim_in = rows_clamp;
         end else begin
            cols_lim_in = cols_clamp;
         end
         row_in = '0;
         col_in = '0;
      end else if (cell_fire) begin
         if (has_below) begin
            row_in = RW'(row_inc);
         end else begin
            row_in = '0;
            col_in = last_col ? '0 : CW'(col_inc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_lim_ff <= RCW'(ROWS_RST);
         cols_lim_ff <= CCW'(COLS_RST);
         row_ff      <= '0;
         col_ff      <= '0;
      end else begin
         rows_lim_ff <= rows_lim_in;
         cols_lim_ff <= cols_lim_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
      end
   end

endmodule

>>> design/gmps_dp.sv
// cell sum datapath, running best and two-entry result buffer
module gmps_dp
   import gmps_pkg::*;
#(
   parameter int RW = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cell_fire,
   input  logic                 grid_clear,
   input  logic [VALUE_W-1:0]   cell_value,
   input  logic [RW-1:0]        cell_row,
   input  cell_ctl_type         cell_ctl,
   input  logic [SUM_W-1:0]     rd_data,
   output logic                 wr_en,
   output logic [RW-1:0]        wr_addr,
   output logic [SUM_W-1:0]     wr_data,
   output dp_status_type        status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SUM_W-1:0]     rsp_best_value,
   output logic [ROW_OUT_W-1:0] rsp_best_row
);

   logic                 b_valid_ff, b_valid_in;
   logic [VALUE_W-1:0]   b_value_ff;
   logic [RW-1:0]        b_row_ff;
   cell_ctl_type         b_ctl_ff;
   logic [SUM_W-1:0]     cur_ff, above_ff;
   logic [SUM_W-1:0]     best_ff, best_in;
   logic [RW-1:0]        best_row_ff, best_row_in;
   logic                 out_valid_ff, out_valid_in;
   logic [SUM_W-1:0]     out_value_ff, out_value_in;
   logic [RW-1:0]        out_row_ff, out_row_in;
   logic                 spr_valid_ff, spr_valid_in;
   logic [SUM_W-1:0]     spr_value_ff, spr_value_in;
   logic [RW-1:0]        spr_row_ff, spr_row_in;

   logic [SUM_W-1:0]     same, above, below, best2, best3;
   logic [SUM_W:0]       sum_wide;
   logic [SUM_W-1:0]     sum;
   logic                 take;
   logic [SUM_W-1:0]     cand_value;
   logic [RW-1:0]        cand_row;
   logic                 b_last;
   logic                 out_pop;
   logic                 out_push;
   logic [1:0]           out_used;

   always_comb begin
      same     = b_ctl_ff.single_row ? rd_data : cur_ff;
      above    = (b_row_ff != '0) ? above_ff : '0;
      below    = b_ctl_ff.has_below ? rd_data : '0;
      best2    = (above > same) ? above : same;
      best3    = (below > best2) ? below : best2;
      sum_wide = {1'b0, best3} + (SUM_W + 1)'(b_value_ff);
      if (b_ctl_ff.first_col) begin
         sum = SUM_W'(b_value_ff);
      end else if (sum_wide[SUM_W]) begin
         sum = '1;
      end else begin
         sum = sum_wide[SUM_W-1:0];
      end
   end

   assign wr_en   = b_valid_ff;
   assign wr_addr = b_row_ff;
   assign wr_data = sum;

   always_comb begin
      take       = (b_row_ff == '0) || (sum > best_ff);
      cand_value = take ? sum : best_ff;
      cand_row   = take ? b_row_ff : best_row_ff;
   end

   assign b_last   = b_valid_ff && b_ctl_ff.last_cell;
   assign out_pop  = out_valid_ff && rsp_ready;
   assign out_push = b_last && !grid_clear;

   always_comb begin
      b_valid_in   = cell_fire;
      best_in      = best_ff;
      best_row_in  = best_row_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_row_in   = out_row_ff;
      spr_valid_in = spr_valid_ff;
      spr_value_in = spr_value_ff;
      spr_row_in   = spr_row_ff;
      if (out_pop) begin
         if (spr_valid_ff) begin
            out_value_in = spr_value_ff;
            out_row_in   = spr_row_ff;
            spr_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (out_push) begin
         if (out_valid_in) begin
            spr_valid_in = 1'b1;
            spr_value_in = cand_value;
            spr_row_in   = cand_row;
         end else begin
            out_valid_in = 1'b1;
            out_value_in = cand_value;
            out_row_in   = cand_row;
         end
      end
      if (grid_clear) begin
         best_in     = '0;
         best_row_in = '0;
      end else if (b_last) begin
         best_in     = '0;
         best_row_in = '0;
      end else if (b_valid_ff && b_ctl_ff.last_col) begin
         best_in     = cand_value;
         best_row_in = cand_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         best_ff      <= '0;
         best_row_ff  <= '0;
         out_valid_ff <= 1'b0;
         spr_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         best_ff      <= best_in;
         best_row_ff  <= best_row_in;
         out_valid_ff <= out_valid_in;
         spr_valid_ff <= spr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_fire) begin
         b_value_ff <= cell_value;
         b_row_ff   <= cell_row;
         b_ctl_ff   <= cell_ctl;
      end
      if (b_valid_ff) begin
         cur_ff   <= rd_data;
         above_ff <= cur_ff;
      end
      out_value_ff <= out_value_in;
      out_row_ff   <= out_row_in;
      spr_value_ff <= spr_value_in;
      spr_row_ff   <= spr_row_in;
   end

   // buffer slots still taken after this edge, the pending last cell included
   assign out_used = {1'b0, out_valid_ff} + {1'b0, spr_valid_ff} + {1'b0, b_last}
                     - {1'b0, out_pop};

   always_comb begin
      status.out_full = (out_used >= 2'd2);
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_best_value = out_value_ff;
   assign rsp_best_row   = ROW_OUT_W'(out_row_ff);

endmodule

>>> design/grid_max_path_sum.sv
// top level of the grid max path sum block
//
// cells enter on the req_ channel one beat per cell, column by column from
// the rightmost column to the leftmost, rows ascending within a column
// each cell's sum is its value plus the best of up to three neighbor sums
// from the column to its right; the previous column lives in a one-port
// write, one-port read memory with a registered read
// after the last cell of the leftmost column one beat leaves on rsp_:
// the best sum of that column and the lowest row that reaches it
// throughput: one cell per cycle, set by one memory read and one write per cell
// a last cell is registered in the b_ stage, its result then in out_ or spr_
// a stalled rsp_ channel holds its beat and up to one more in a spare slot;
// cells keep flowing, only a last cell that would need a third slot waits
// csr_ writes set rows_used (index 0) and cols_used (index 1), clamped to the
// supported range, and restart the grid in progress
// reset clears the counters and the running best, selects min(MAX_ROWS, 64)
// rows and min(MAX_COLS, 256) columns, and leaves the memory uninitialized
module grid_max_path_sum
   import gmps_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_W-1:0]    req_cell_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SUM_W-1:0]      rsp_best_value,
   output logic [ROW_OUT_W-1:0]  rsp_best_row,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   dp_status_type    status;
   cell_ctl_type     cell_ctl;
   logic             cell_fire;
   logic             grid_clear;
   logic [RW-1:0]    rd_addr;
   logic [RW-1:0]    cell_row;
   logic [SUM_W-1:0] rd_data;
   logic             wr_en;
   logic [RW-1:0]    wr_addr;
   logic [SUM_W-1:0] wr_data;

   gmps_seq #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .RW       (RW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .cell_fire  (cell_fire),
      .grid_clear (grid_clear),
      .rd_addr    (rd_addr),
      .cell_row   (cell_row),
      .cell_ctl   (cell_ctl)
   );

   gmps_col_ram #(
      .DEPTH (MAX_ROWS),
      .AW    (RW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cell_fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gmps_dp #(
      .RW (RW)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cell_fire      (cell_fire),
      .grid_clear     (grid_clear),
      .cell_value     (req_cell_value),
      .cell_row       (cell_row),
      .cell_ctl       (cell_ctl),
      .rd_data        (rd_data),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_best_value (rsp_best_value),
      .rsp_best_row   (rsp_best_row)
   );

endmodule

>>> tb/grid_max_path_sum_checker.sv
// checker for the grid max path sum block: watches the channels, predicts and compares
`timescale 1ns / 100ps

module grid_max_path_sum_checker
   import gmps_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [VALUE_W-1:0]    req_cell_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [SUM_W-1:0]      rsp_best_value,
   input  logic [ROW_OUT_W-1:0]  rsp_best_row,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           mismatch_count,
   output int unsigned           results_pending
);

   typedef struct packed {
      logic [SUM_W-1:0]     value;
      logic [ROW_OUT_W-1:0] row;
   } grid_best_type;

   localparam logic [SUM_W-1:0] SUM_CEIL = '1;

   logic [SUM_W-1:0]      prev_col_sum [MAX_ROWS];
   logic [SUM_W-1:0]      upper_prior;
   int unsigned           cur_row;
   int unsigned           done_cols;
   logic [SUM_W-1:0]      lead_sum;
   logic [ROW_OUT_W-1:0]  lead_row;
   logic [ROWS_REG_W-1:0] rows_reg;
   logic [COLS_REG_W-1:0] cols_reg;
   grid_best_type         grid_best_q [$];
   int unsigned           errors = 0;

   function automatic int unsigned fit_range(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic restart_grid();
      upper_prior = '0;
      cur_row     = 0;
      done_cols   = 0;
      lead_sum    = '0;
      lead_row    = '0;
   endtask

   task automatic accumulate_cell(input logic [VALUE_W-1:0] gold);
      int unsigned      rows;
      int unsigned      cols;
      int unsigned      r;
      logic [SUM_W:0]   total;
      logic [SUM_W-1:0] nb;
      logic [SUM_W-1:0] sum;
      grid_best_type    entry;
      rows = fit_range(rows_reg, MAX_ROWS);
      cols = fit_range(cols_reg, MAX_COLS);
      r = (cur_row >= rows) ? rows - 1 : cur_row;
      if (done_cols == 0) begin
         sum = SUM_W'(gold);
      end else begin
         nb = prev_col_sum[r];
         if (r > 0 && upper_prior > nb) nb = upper_prior;
         if (r + 1 < rows && prev_col_sum[r + 1] > nb) nb = prev_col_sum[r + 1];
         total = {1'b0, nb} + (SUM_W + 1)'(gold);
         sum = total[SUM_W] ? SUM_CEIL : total[SUM_W-1:0];
      end
      upper_prior     = prev_col_sum[r];
      prev_col_sum[r] = sum;
      // ties keep the lowest row
      if (done_cols + 1 >= cols && (r == 0 || sum > lead_sum)) begin
         lead_sum = sum;
         lead_row = ROW_OUT_W'(r);
      end
      if (r + 1 < rows) begin
         cur_row = r + 1;
      end else begin
         cur_row     = 0;
         upper_prior = '0;
         if (done_cols + 1 < cols) begin
            done_cols = done_cols + 1;
         end else begin
            entry.value = lead_sum;
            entry.row   = lead_row;
            grid_best_q.push_back(entry);
            restart_grid();
         end
      end
   endtask

   always @(posedge clock) begin
      grid_best_type want;
      if (reset) begin
         for (int i = 0; i < MAX_ROWS; i++) prev_col_sum[i] = '0;
         restart_grid();
         rows_reg = ROWS_REG_W'(MAX_ROWS);
         cols_reg = COLS_REG_W'(MAX_COLS);
         grid_best_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROWS_USED) rows_reg = csr_wdata[ROWS_REG_W-1:0];
            else cols_reg = csr_wdata[COLS_REG_W-1:0];
            restart_grid();
         end
         if (req_valid && req_ready) accumulate_cell(req_cell_value);
         if (rsp_valid && rsp_ready) begin
            if (grid_best_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat, expected none, actual value %0d row %0d",
                        $time, rsp_best_value, rsp_best_row);
            end else begin
               want = grid_best_q.pop_front();
               if (rsp_best_value !== want.value) begin
                  errors++;
                  $display("%0t: best_value expected %0d actual %0d",
                           $time, want.value, rsp_best_value);
               end
               if (rsp_best_row !== want.row) begin
                  errors++;
                  $display("%0t: best_row expected %0d actual %0d",
                           $time, want.row, rsp_best_row);
               end
            end
         end
      end
      mismatch_count  <= errors;
      results_pending <= grid_best_q.size();
   end

endmodule

>>> tb/grid_max_path_sum_tb.sv
// testbench top for the grid max path sum block: stimulus, flow control and verdict
`timescale 1ns / 100ps

module grid_max_path_sum_tb;
   import gmps_pkg::*;

   localparam int unsigned RANDOM_CELLS    = 240;
   localparam int unsigned RSP_HOLD_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES   = 4;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [VALUE_W-1:0]    req_cell_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [SUM_W-1:0]      rsp_best_value;
   logic [ROW_OUT_W-1:0]  rsp_best_row;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index      = CSR_ROWS_USED;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;
   int unsigned           mismatch_count;
   int unsigned           results_pending;

   bit                    quiet          = 1'b0;
   int unsigned           hold_off_asks  = 0;
   int unsigned           cells_sent     = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   grid_max_path_sum u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_best_value (rsp_best_value),
      .rsp_best_row   (rsp_best_row),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   grid_max_path_sum_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cell_value  (req_cell_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_best_value  (rsp_best_value),
      .rsp_best_row    (rsp_best_row),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   function automatic int unsigned idle_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_gold();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      if (roll == 2) return VALUE_W'($urandom_range(0, 3));
      return VALUE_W'($urandom);
   endfunction

   function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic send_cell(input logic [VALUE_W-1:0] gold);
      int unsigned gap;
      gap = quiet ? 0 : idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cell_value <= gold;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cells_sent++;
   endtask

   task automatic send_cells(input int unsigned count);
      repeat (count) send_cell(pick_gold());
   endtask

   // wait until every grid result has been taken
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_grid(input logic [CSR_DATA_W-1:0] rows_data,
                           input logic [CSR_DATA_W-1:0] cols_data);
      csr_valid <= 1'b1;
      csr_index <= CSR_ROWS_USED;
      csr_wdata <= rows_data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_COLS_USED;
      csr_wdata <= cols_data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned holds_done;
      stall_left = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_off_asks) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready  <= 1'b1;
            stall_left = quiet ? 0 : idle_len();
         end
      end
   end

   initial begin : req_side
      int unsigned random_start;
      int unsigned rows_low;
      int unsigned cols_low;
      int unsigned rows;
      int unsigned cols;
      int unsigned roll;
      int unsigned grids;
      bit          first;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset sizes, partial grid abandoned by the register writes
      send_cell(16'h0000);
      send_cell(16'hFFFF);
      send_cell(16'h0001);
      settle();
      set_grid(16'd1, 16'd1);
      send_cell(16'h0000);
      send_cell(16'hFFFF);
      settle();
      // zero sizes clamp up to one
      set_grid(16'h0000, 16'h0200);
      send_cell(16'hAAAA);
      settle();
      // all rows tie, then the bottom row wins
      set_grid(16'd3, 16'd2);
      repeat (6) send_cell(16'd5);
      send_cell(16'd1);
      send_cell(16'd2);
      send_cell(16'd3);
      send_cell(16'd0);
      send_cell(16'd0);
      send_cell(16'hFFFF);
      settle();
      // upper register bits are dropped
      set_grid(16'hFF82, 16'hFE03);
      send_cell(16'hFFFF);
      send_cell(16'h0000);
      send_cell(16'h0000);
      send_cell(16'hFFFF);
      send_cell(16'd123);
      send_cell(16'hFFFF);
      settle();

      // largest sizes
      set_grid(16'h007F, 16'd1);
      repeat (63) send_cell(VALUE_W'($urandom_range(0, 65534)));
      send_cell(16'hFFFF);
      settle();
      set_grid(16'd1, 16'h01FF);
      repeat (256) send_cell(16'hFFFF);
      settle();
      set_grid(16'd64, 16'd256);
      send_cells(20);

      random_start = cells_sent;
      first        = 1'b1;
      while (cells_sent - random_start < RANDOM_CELLS) begin
         settle();
         roll = $urandom_range(0, 9);
         if (first) begin
            rows_low = 2;
            cols_low = 2;
         end else if (roll == 0) begin
            rows_low = $urandom_range(1, 64);
            cols_low = $urandom_range(1, 2);
         end else if (roll == 1) begin
            rows_low = $urandom_range(1, 2);
            cols_low = $urandom_range(1, 40);
         end else if (roll == 2) begin
            rows_low = $urandom_range(0, 1) ? $urandom_range(65, 127) : 0;
            cols_low = $urandom_range(0, 1) ? $urandom_range(1, 3) : 0;
         end else begin
            rows_low = $urandom_range(1, 6);
            cols_low = $urandom_range(1, 6);
         end
         rows = fit_size(rows_low, 64);
         cols = fit_size(cols_low, 256);
         set_grid(CSR_DATA_W'(($urandom & 32'hFF80) | rows_low),
                  CSR_DATA_W'(($urandom & 32'hFE00) | cols_low));
         quiet = first || ($urandom_range(0, 4) == 0);
         // long receiver hold so the block backs up into the input
         if (first) hold_off_asks++;
         grids = first ? 10 : $urandom_range(1, 4);
         repeat (grids) send_cells(rows * cols);
         if (rows * cols > 1 && $urandom_range(0, 5) == 0)
            send_cells($urandom_range(1, rows * cols - 1));
         first = 1'b0;
      end
      quiet = 1'b0;
      settle();

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

>>> filelist.f
design/gmps_pkg.sv
design/gmps_col_ram.sv
design/gmps_seq.sv
design/gmps_dp.sv
design/grid_max_path_sum.sv
tb/grid_max_path_sum_checker.sv
tb/grid_max_path_sum_tb.sv
